>>> rtl/bgi_pkg.sv
// ----------------------------------------------------------------------------
// bgi_pkg
// Shared widths, reset values, register codes and stage controls of the
// bilinear grid interpolator.
// ----------------------------------------------------------------------------
package bgi_pkg;

  // field widths
  localparam int Q_W        = 24;
  localparam int GP_W       = 9;
  localparam int ORG_W      = 24;
  localparam int INV_W      = 24;
  localparam int VAL_W      = 32;
  localparam int LD_IDX_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int IN_TDATA_W = 96;
  localparam int OUT_TDATA_W = 32;

  localparam int DEF_MAX_GRID_POINTS = 256;
  localparam int MIN_POINTS = 2;
  localparam int NUM_BANKS  = 4;

  // fixed point layout
  localparam int FRAC_LIMIT = 32;
  localparam int FRAC_BITS  = 16;
  localparam int U_FRAC     = 28;
  localparam int D_W        = Q_W + 1;
  localparam int U_W        = D_W + INV_W;
  localparam int SH_W       = U_FRAC - FRAC_BITS;
  localparam int US_W       = U_W - SH_W;
  localparam int UHI_W      = U_W - 1 - U_FRAC;
  localparam int FX_W       = $clog2(FRAC_LIMIT) + FRAC_BITS + 2;
  localparam int FRAC_LIM_VAL = FRAC_LIMIT * (2 ** FRAC_BITS);
  localparam int DS_W       = VAL_W + 1;
  localparam int P_W        = DS_W + FX_W;
  localparam int R_W        = P_W - FRAC_BITS;
  localparam int PC_W       = R_W + FX_W;
  localparam int V_W        = PC_W - FRAC_BITS + 1;

  // register reset values
  localparam logic [GP_W-1:0]         GRID_POINTS_RST = GP_W'(256);
  localparam logic signed [ORG_W-1:0] GRID_ORIGIN_RST = '0;
  localparam logic [INV_W-1:0]        INV_STEP_RST    = INV_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_POINTS   = 2'd0,
    REG_GRID_ORIGIN   = 2'd1,
    REG_INV_CELL_STEP = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef struct packed {
    logic sub_stage;
    logic mul_stage;
    logic loc_stage;
  } locate_en_t;

  typedef struct packed {
    logic row_mul;
    logic row_add;
    logic col_mul;
    logic out_stage;
  } blend_en_t;

endpackage

>>> rtl/bgi_locate.sv
// ----------------------------------------------------------------------------
// bgi_locate
// Three stages for one axis: offset from origin, scale by the reciprocal
// step, then clamp the cell index and saturate the signed fraction.
// ----------------------------------------------------------------------------
module bgi_locate #(
  parameter int MAX_GRID_POINTS = bgi_pkg::DEF_MAX_GRID_POINTS,
  localparam int IDX_W = $clog2(MAX_GRID_POINTS)
) (
  input  logic                              clk_i,
  input  bgi_pkg::locate_en_t               en_i,
  input  logic signed [bgi_pkg::Q_W-1:0]    coord_i,
  input  logic signed [bgi_pkg::ORG_W-1:0]  grid_origin_i,
  input  logic [bgi_pkg::INV_W-1:0]         inv_cell_step_i,
  input  logic [bgi_pkg::GP_W-1:0]          grid_points_i,
  output logic [IDX_W-1:0]                  idx_o,
  output logic signed [bgi_pkg::FX_W-1:0]   frac_o
);
  import bgi_pkg::*;

  localparam int PW_A = $clog2(MAX_GRID_POINTS + 1);
  localparam int PW   = (PW_A > GP_W) ? PW_A : GP_W;
  localparam logic signed [US_W-1:0] LIM_P = US_W'(FRAC_LIM_VAL);
  localparam logic signed [US_W-1:0] LIM_N = -LIM_P;

  logic signed [D_W-1:0]  d_q;
  logic signed [U_W-1:0]  u_q;
  logic signed [D_W-1:0]  inv_s;
  logic signed [U_W-1:0]  u_d;
  logic [PW-1:0]          p_ext;
  logic [PW-1:0]          p_clamp;
  logic [IDX_W-1:0]       hi;
  logic [UHI_W-1:0]       u_hi;
  logic [IDX_W-1:0]       idx_d;
  logic signed [US_W-1:0] ush;
  logic signed [US_W-1:0] f_raw;
  logic signed [US_W-1:0] f_sat;
  logic [IDX_W-1:0]       idx_q;
  logic signed [FX_W-1:0] frac_q;

  // highest usable cell index from the point count
  always_comb begin
    p_ext = PW'(grid_points_i);
    if (p_ext < PW'(MIN_POINTS)) begin
      p_clamp = PW'(MIN_POINTS);
    end else if (p_ext > PW'(MAX_GRID_POINTS)) begin
      p_clamp = PW'(MAX_GRID_POINTS);
    end else begin
      p_clamp = p_ext;
    end
    hi = IDX_W'(p_clamp - PW'(MIN_POINTS));
  end

  assign inv_s = $signed({1'b0, inv_cell_step_i});
  assign u_d   = d_q * inv_s;

  always_comb begin
    u_hi = u_q[U_W-2:U_FRAC];
    if (u_q[U_W-1]) begin
      idx_d = '0;
    end else if (u_hi > UHI_W'(hi)) begin
      idx_d = hi;
    end else begin
      idx_d = IDX_W'(u_hi);
    end
    // floor shift of u minus the whole cells taken by the index
    ush   = $signed(u_q[U_W-1:SH_W]);
    f_raw = ush - $signed(US_W'({idx_d, {FRAC_BITS{1'b0}}}));
    if (f_raw > LIM_P) begin
      f_sat = LIM_P;
    end else if (f_raw < LIM_N) begin
      f_sat = LIM_N;
    end else begin
      f_sat = f_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sub_stage) begin
      d_q <= $signed({coord_i[Q_W-1], coord_i}) -
             $signed({grid_origin_i[ORG_W-1], grid_origin_i});
    end
    if (en_i.mul_stage) begin
      u_q <= u_d;
    end
    if (en_i.loc_stage) begin
      idx_q  <= idx_d;
      frac_q <= $signed(f_sat[FX_W-1:0]);
    end
  end

  assign idx_o  = idx_q;
  assign frac_o = frac_q;

endmodule

>>> rtl/bgi_grid_mem.sv
// ----------------------------------------------------------------------------
// bgi_grid_mem
// Grid store split in four banks by column and row parity, so the four
// corners of a cell are read in the same cycle.
// ----------------------------------------------------------------------------
module bgi_grid_mem #(
  parameter int MAX_GRID_POINTS = bgi_pkg::DEF_MAX_GRID_POINTS,
  localparam int IDX_W = $clog2(MAX_GRID_POINTS)
) (
  input  logic                                           clk_i,
  input  logic                                           rd_en_i,
  input  logic [IDX_W-1:0]                               rd_col_i,
  input  logic [IDX_W-1:0]                               rd_row_i,
  input  logic                                           wr_en_i,
  input  logic [IDX_W-1:0]                               wr_col_i,
  input  logic [IDX_W-1:0]                               wr_row_i,
  input  logic [bgi_pkg::VAL_W-1:0]                      wr_data_i,
  output logic [bgi_pkg::NUM_BANKS-1:0][bgi_pkg::VAL_W-1:0] rd_data_o
);
  import bgi_pkg::*;

  localparam int HW         = IDX_W - 1;
  localparam int BANK_DEPTH = 1 << (2 * HW);

  logic [IDX_W-1:0]  col_nx;
  logic [IDX_W-1:0]  row_nx;
  logic [2*HW-1:0]   wr_addr;

  assign col_nx  = IDX_W'(rd_col_i + 1'b1);
  assign row_nx  = IDX_W'(rd_row_i + 1'b1);
  assign wr_addr = {wr_row_i[IDX_W-1:1], wr_col_i[IDX_W-1:1]};

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic CP = 1'(b % 2);
    localparam logic RP = 1'(b / 2);

    logic [VAL_W-1:0] bank_mem [BANK_DEPTH];
    logic [VAL_W-1:0] rd_q;
    logic [IDX_W-1:0] col_sel;
    logic [IDX_W-1:0] row_sel;
    logic [2*HW-1:0]  rd_addr;
    logic             wr_hit;

    // this bank holds the corner whose parity matches it
    assign col_sel = (rd_col_i[0] == CP) ? rd_col_i : col_nx;
    assign row_sel = (rd_row_i[0] == RP) ? rd_row_i : row_nx;
    assign rd_addr = {row_sel[IDX_W-1:1], col_sel[IDX_W-1:1]};
    assign wr_hit  = wr_en_i && (wr_col_i[0] == CP) && (wr_row_i[0] == RP);

    always_ff @(posedge clk_i) begin
      if (wr_hit) begin
        bank_mem[wr_addr] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_q <= bank_mem[rd_addr];
      end
    end

    assign rd_data_o[b] = rd_q;
  end

endmodule

>>> rtl/bgi_blend.sv
// ----------------------------------------------------------------------------
// bgi_blend
// Bilinear blend of the four corner samples in four stages: row products,
// row sums, column product, then final sum with clamp and saturation.
// ----------------------------------------------------------------------------
module bgi_blend (
  input  logic                                              clk_i,
  input  bgi_pkg::blend_en_t                                en_i,
  input  logic [bgi_pkg::NUM_BANKS-1:0][bgi_pkg::VAL_W-1:0] bank_data_i,
  input  logic                                              par_x_i,
  input  logic                                              par_y_i,
  input  logic signed [bgi_pkg::FX_W-1:0]                   fx_i,
  input  logic signed [bgi_pkg::FX_W-1:0]                   fy_i,
  output logic [bgi_pkg::VAL_W-1:0]                         result_o
);
  import bgi_pkg::*;

  logic [VAL_W-1:0]       s00, s01, s10, s11;
  logic signed [DS_W-1:0] ds0, ds1;
  logic signed [P_W-1:0]  prod0_d, prod1_d;
  logic signed [P_W-1:0]  prod0_q, prod1_q;
  logic [VAL_W-1:0]       s00_q, s10_q;
  logic signed [FX_W-1:0] fy5_q, fy6_q;
  logic signed [R_W-1:0]  r0_d, r1_d;
  logic signed [R_W-1:0]  r0_q, r1_q, r0_7q;
  logic signed [R_W-1:0]  dr;
  logic signed [PC_W-1:0] prodc_d, prodc_q;
  logic signed [V_W-1:0]  v_sum;
  logic [VAL_W-1:0]       res_d, res_q;

  // bank index is {row parity, column parity}
  assign s00 = bank_data_i[{par_y_i, par_x_i}];
  assign s01 = bank_data_i[{par_y_i, ~par_x_i}];
  assign s10 = bank_data_i[{~par_y_i, par_x_i}];
  assign s11 = bank_data_i[{~par_y_i, ~par_x_i}];

  assign ds0     = $signed({1'b0, s01}) - $signed({1'b0, s00});
  assign ds1     = $signed({1'b0, s11}) - $signed({1'b0, s10});
  assign prod0_d = ds0 * fx_i;
  assign prod1_d = ds1 * fx_i;

  // dropping the low bits of a signed value is the floor shift
  assign r0_d = R_W'($signed({1'b0, s00_q})) + $signed(prod0_q[P_W-1:FRAC_BITS]);
  assign r1_d = R_W'($signed({1'b0, s10_q})) + $signed(prod1_q[P_W-1:FRAC_BITS]);

  assign dr      = r1_q - r0_q;
  assign prodc_d = dr * fy6_q;

  always_comb begin
    v_sum = V_W'(r0_7q) + V_W'($signed(prodc_q[PC_W-1:FRAC_BITS]));
    if (v_sum[V_W-1]) begin
      res_d = '0;
    end else if (|v_sum[V_W-2:VAL_W]) begin
      res_d = '1;
    end else begin
      res_d = v_sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.row_mul) begin
      prod0_q <= prod0_d;
      prod1_q <= prod1_d;
      s00_q   <= s00;
      s10_q   <= s10;
      fy5_q   <= fy_i;
    end
    if (en_i.row_add) begin
      r0_q  <= r0_d;
      r1_q  <= r1_d;
      fy6_q <= fy5_q;
    end
    if (en_i.col_mul) begin
      prodc_q <= prodc_d;
      r0_7q   <= r0_q;
    end
    if (en_i.out_stage) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

>>> rtl/bilinear_grid_interpolator_top.sv
// ----------------------------------------------------------------------------
// bilinear_grid_interpolator_top
// Loads grid samples and answers bilinear queries through an eight stage
// pipeline over a four bank grid store.
//
//   channel  | dir | handshake           | payload
//   s_axis   | in  | tvalid/tready       | tuser: action; tdata: load/query word
//   m_axis   | out | tvalid/tready       | tdata: interpolated
//   cfg      | in  | cfg_we_i, no wait   | cfg_idx_i, cfg_data_i
//
// One word is accepted per cycle unless a stall at m_axis has filled the
// pipeline; a query passes the stages subtract, multiply, locate, bank read,
// row product, row sum, column product and output before its result is given.
// A load writes its bank at the bank read stage and gives no word.
// Reset clears the valid bits and loads the configuration reset values; data
// registers are not reset, and grid contents stay undefined until loaded.
// A stall at m_axis holds only the full stages in a row before the output,
// so empty stages keep filling while the result waits.
// ----------------------------------------------------------------------------
module bilinear_grid_interpolator_top #(
  parameter int MAX_GRID_POINTS = bgi_pkg::DEF_MAX_GRID_POINTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bgi_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [7:0] load_col, [15:8] load_row, [47:16] load_value,
  // [71:48] query_x, [95:72] query_y
  input  logic [bgi_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // [0] action
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] interpolated
  output logic [bgi_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);
  import bgi_pkg::*;

  localparam int IDX_W  = $clog2(MAX_GRID_POINTS);
  localparam int NSTAGE = 8;
  localparam logic signed [FX_W-1:0] FX_LIM_P = FX_W'(FRAC_LIM_VAL);
  localparam logic signed [FX_W-1:0] FX_LIM_N = -FX_LIM_P;

  logic [GP_W-1:0]         grid_points_q;
  logic signed [ORG_W-1:0] grid_origin_q;
  logic [INV_W-1:0]        inv_cell_step_q;

  logic [NSTAGE:1]   v_q;
  logic [NSTAGE+1:1] en;

  logic [LD_IDX_W-1:0] in_col, in_row;
  logic [VAL_W-1:0]    in_val;
  logic signed [Q_W-1:0] in_qx, in_qy;
  logic                in_store;

  action_e          act_q   [1:3];
  logic             store_q [1:3];
  logic [IDX_W-1:0] col_q   [1:3];
  logic [IDX_W-1:0] row_q   [1:3];
  logic [VAL_W-1:0] val_q   [1:3];

  logic [IDX_W-1:0]       ix3, iy3;
  logic signed [FX_W-1:0] fx3, fy3;
  logic                   par_x4_q, par_y4_q;
  logic signed [FX_W-1:0] fx4_q, fy4_q;
  logic                   wr_en;

  locate_en_t loc_en;
  blend_en_t  bl_en;
  logic [NUM_BANKS-1:0][VAL_W-1:0] bank_data;
  logic [VAL_W-1:0] result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_points_q   <= GRID_POINTS_RST;
      grid_origin_q   <= GRID_ORIGIN_RST;
      inv_cell_step_q <= INV_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GRID_POINTS:   grid_points_q   <= cfg_data_i[GP_W-1:0];
        REG_GRID_ORIGIN:   grid_origin_q   <= $signed(cfg_data_i[ORG_W-1:0]);
        REG_INV_CELL_STEP: inv_cell_step_q <= cfg_data_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage takes new data when empty or when its successor moves
  always_comb begin
    en[NSTAGE+1] = m_axis_tready_i;
    for (int k = NSTAGE; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[1];
  assign m_axis_tvalid_o = v_q[NSTAGE];
  assign m_axis_tdata_o  = result;

  assign in_col   = s_axis_tdata_i[7:0];
  assign in_row   = s_axis_tdata_i[15:8];
  assign in_val   = s_axis_tdata_i[47:16];
  assign in_qx    = $signed(s_axis_tdata_i[71:48]);
  assign in_qy    = $signed(s_axis_tdata_i[95:72]);
  assign in_store = (32'(in_col) < 32'(MAX_GRID_POINTS)) &&
                    (32'(in_row) < 32'(MAX_GRID_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= s_axis_tvalid_i;
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      // loads leave the pipeline once written
      if (en[4]) v_q[4] <= v_q[3] && (act_q[3] == ACT_QUERY);
      for (int k = 5; k <= NSTAGE; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      act_q[1]   <= action_e'(s_axis_tuser_i);
      store_q[1] <= in_store;
      col_q[1]   <= IDX_W'(in_col);
      row_q[1]   <= IDX_W'(in_row);
      val_q[1]   <= in_val;
    end
    for (int k = 2; k <= 3; k++) begin
      if (en[k]) begin
        act_q[k]   <= act_q[k-1];
        store_q[k] <= store_q[k-1];
        col_q[k]   <= col_q[k-1];
        row_q[k]   <= row_q[k-1];
        val_q[k]   <= val_q[k-1];
      end
    end
    if (en[4]) begin
      par_x4_q <= ix3[0];
      par_y4_q <= iy3[0];
      fx4_q    <= fx3;
      fy4_q    <= fy3;
    end
  end

  assign loc_en = '{sub_stage: en[1], mul_stage: en[2], loc_stage: en[3]};
  assign bl_en  = '{row_mul: en[5], row_add: en[6], col_mul: en[7], out_stage: en[8]};

  bgi_locate #(
    .MAX_GRID_POINTS(MAX_GRID_POINTS)
  ) u_locate_x (
    .clk_i          (clk_i),
    .en_i           (loc_en),
    .coord_i        (in_qx),
    .grid_origin_i  (grid_origin_q),
    .inv_cell_step_i(inv_cell_step_q),
    .grid_points_i  (grid_points_q),
    .idx_o          (ix3),
    .frac_o         (fx3)
  );

  bgi_locate #(
    .MAX_GRID_POINTS(MAX_GRID_POINTS)
  ) u_locate_y (
    .clk_i          (clk_i),
    .en_i           (loc_en),
    .coord_i        (in_qy),
    .grid_origin_i  (grid_origin_q),
    .inv_cell_step_i(inv_cell_step_q),
    .grid_points_i  (grid_points_q),
    .idx_o          (iy3),
    .frac_o         (fy3)
  );

  assign wr_en = en[4] && v_q[3] && (act_q[3] == ACT_LOAD) && store_q[3];

  bgi_grid_mem #(
    .MAX_GRID_POINTS(MAX_GRID_POINTS)
  ) u_grid_mem (
    .clk_i    (clk_i),
    .rd_en_i  (en[4]),
    .rd_col_i (ix3),
    .rd_row_i (iy3),
    .wr_en_i  (wr_en),
    .wr_col_i (col_q[3]),
    .wr_row_i (row_q[3]),
    .wr_data_i(val_q[3]),
    .rd_data_o(bank_data)
  );

  bgi_blend u_blend (
    .clk_i      (clk_i),
    .en_i       (bl_en),
    .bank_data_i(bank_data),
    .par_x_i    (par_x4_q),
    .par_y_i    (par_y4_q),
    .fx_i       (fx4_q),
    .fy_i       (fy4_q),
    .result_o   (result)
  );

  // a load never reaches the blend stages
  a_load_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && (act_q[3] == ACT_LOAD) && en[4]) |=> !v_q[4])
    else $error("load word entered blend stages");

  // located fractions stay within the extrapolation limit
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> ((fx3 <= FX_LIM_P) && (fx3 >= FX_LIM_N) &&
                (fy3 <= FX_LIM_P) && (fy3 >= FX_LIM_N)))
    else $error("fraction outside limit");

  // a full pipeline with a stalled output takes no new word
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&v_q) && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("word accepted into full stalled pipeline");

  // a bank write comes only from a valid load word
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (v_q[3] && (act_q[3] == ACT_LOAD) && !(v_q[4] && !en[5])))
    else $error("bank write without a moving load word");

endmodule
